[src/att_pkg.sv]
// Shared constants, types and helpers of the ANSI text terminal.
package att_pkg;

    localparam int unsigned MAX_COLS     = 80;
    localparam int unsigned MAX_ROWS     = 32;
    localparam int unsigned ARG_SLOTS    = 8;
    localparam int unsigned SCREEN_CELLS = MAX_COLS * MAX_ROWS;
    localparam int unsigned ALL_CELLS    = 2 * SCREEN_CELLS;
    localparam int unsigned ADDR_W       = $clog2(ALL_CELLS);
    localparam int unsigned COL_W        = 7;
    localparam int unsigned ROW_W        = 5;
    localparam int unsigned ARG_W        = 16;
    localparam int unsigned ARGC_W       = $clog2(ARG_SLOTS + 1);
    localparam int unsigned ARGI_W       = $clog2(ARG_SLOTS);

    localparam logic [ARG_W-1:0] ARG_LIMIT = 16'hFFFF;
    localparam logic [6:0] COLS_RESET = 7'd40;
    localparam logic [5:0] ROWS_RESET = 6'd25;

    // Transaction kinds on the input channel.
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // Parser modes.
    localparam logic [1:0] PM_NORMAL = 2'd0;
    localparam logic [1:0] PM_ESC    = 2'd1;
    localparam logic [1:0] PM_CSI    = 2'd2;

    // Byte codes.
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SAVE = 8'h37;
    localparam logic [7:0] CH_REST = 8'h38;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;
    localparam logic [7:0] FIN_LO  = 8'h40;
    localparam logic [7:0] FIN_HI  = 8'h7E;
    localparam logic [7:0] FIN_CUU = 8'h41;
    localparam logic [7:0] FIN_CUD = 8'h42;
    localparam logic [7:0] FIN_CUF = 8'h43;
    localparam logic [7:0] FIN_CUB = 8'h44;
    localparam logic [7:0] FIN_CUP = 8'h48;
    localparam logic [7:0] FIN_HVP = 8'h66;
    localparam logic [7:0] FIN_ED  = 8'h4A;
    localparam logic [7:0] FIN_EL  = 8'h4B;
    localparam logic [7:0] FIN_SGR = 8'h6D;
    localparam logic [7:0] FIN_STB = 8'h72;
    localparam logic [7:0] FIN_SCP = 8'h73;
    localparam logic [7:0] FIN_RCP = 8'h75;
    localparam logic [7:0] FIN_SU  = 8'h53;
    localparam logic [7:0] FIN_SD  = 8'h54;
    localparam logic [7:0] FIN_SET = 8'h68;
    localparam logic [7:0] FIN_RST = 8'h6C;

    localparam logic [ARG_W-1:0] MODE_ALT    = 16'd1049;
    localparam logic [ARG_W-1:0] MODE_CURSOR = 16'd25;
    localparam logic [ARG_W-1:0] MODE_WRAP   = 16'd7;

    localparam logic [7:0] PAL_FG_MASK = 8'hF8;
    localparam logic [7:0] PAL_BG_MASK = 8'h0F;
    localparam logic [7:0] PAL_BOLD    = 8'h08;

    typedef struct packed {
        logic accept;
        logic exec;
        logic fill_step;
        logic copy_rd;
        logic copy_wr;
        logic clr_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic plan_copy;
        logic plan_fill;
        logic plan_clr;
        logic fill_last;
        logic copy_last;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic scr,
                                                   input logic [ROW_W-1:0] y,
                                                   input logic [COL_W-1:0] x);
        cell_addr = (scr ? ADDR_W'(SCREEN_CELLS) : '0)
                  + ADDR_W'(y) * ADDR_W'(MAX_COLS) + ADDR_W'(x);
    endfunction

endpackage

[src/att_in_if.sv]
// Input channel of the terminal: byte feed or cell read transactions.
interface att_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic [6:0] read_col;
    logic [4:0] read_row;

    modport source (output valid, output cmd, output data_byte, output read_col,
                    output read_row, input ready);
    modport sink (input valid, input cmd, input data_byte, input read_col,
                  input read_row, output ready);
endinterface

[src/att_out_if.sv]
// Result channel of the terminal: read cell and cursor status.
interface att_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [7:0] cell_palette;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       cursor_shown;
    logic       alt_active;

    modport source (output valid, output cell_char, output cell_palette,
                    output cursor_col, output cursor_row, output cursor_shown,
                    output alt_active, input ready);
    modport sink (input valid, input cell_char, input cell_palette,
                  input cursor_col, input cursor_row, input cursor_shown,
                  input alt_active, output ready);
endinterface

[src/att_ctrl.sv]
// Controller state machine of the terminal: sequences parsing, walks and results.
module att_ctrl
    import att_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_BOOT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_CPRD = 3'd3;
    localparam logic [2:0] S_CPWR = 3'd4;
    localparam logic [2:0] S_FILL = 3'd5;
    localparam logic [2:0] S_ACLR = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_BOOT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_stat.plan_copy) n_state = S_CPRD;
                else if (i_stat.plan_fill) n_state = S_FILL;
                else if (i_stat.plan_clr) n_state = S_ACLR;
                else n_state = S_DONE;
            end
            S_CPRD: begin
                o_cmd.copy_rd = 1'b1;
                n_state = S_CPWR;
            end
            S_CPWR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = i_stat.copy_last ? S_FILL : S_CPRD;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) n_state = S_DONE;
            end
            S_ACLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/att_dp.sv]
// Datapath of the terminal: parser, screen state, walk counters and cell store.
module att_dp
    import att_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_in_cmd,
    input  logic [7:0]       i_in_byte,
    input  logic [COL_W-1:0] i_in_col,
    input  logic [ROW_W-1:0] i_in_row,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [6:0]       i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_char,
    output logic [7:0]       o_out_pal,
    output logic [COL_W-1:0] o_out_col,
    output logic [ROW_W-1:0] o_out_row,
    output logic             o_out_shown,
    output logic             o_out_alt
);

    // Cell store, {palette, char} per cell.
    logic [15:0] r_mem [ALL_CELLS];
    logic [15:0] r_rdata;

    // Latched transaction.
    logic             r_icmd;
    logic [7:0]       r_ibyte;
    logic [COL_W-1:0] r_icol;
    logic [ROW_W-1:0] r_irow;

    logic [6:0] r_cols, n_cols;
    logic [5:0] r_rows, n_rows;

    logic [1:0]       r_mode, n_mode;
    logic [ARG_W-1:0] r_args [ARG_SLOTS];
    logic [ARG_W-1:0] n_args [ARG_SLOTS];
    logic [ARGC_W-1:0] r_argc, n_argc;
    logic r_dseen, n_dseen;
    logic r_priv, n_priv;

    logic [COL_W-1:0] r_col  [2];
    logic [COL_W-1:0] n_col  [2];
    logic [ROW_W-1:0] r_row  [2];
    logic [ROW_W-1:0] n_row  [2];
    logic [COL_W-1:0] r_scol [2];
    logic [COL_W-1:0] n_scol [2];
    logic [ROW_W-1:0] r_srow [2];
    logic [ROW_W-1:0] n_srow [2];
    logic [7:0]       r_pal  [2];
    logic [7:0]       n_pal  [2];
    logic [7:0]       r_spal [2];
    logic [7:0]       n_spal [2];
    logic [ROW_W-1:0] r_top  [2];
    logic [ROW_W-1:0] n_top  [2];
    logic [ROW_W-1:0] r_bot  [2];
    logic [ROW_W-1:0] n_bot  [2];
    logic             r_vis  [2];
    logic             n_vis  [2];
    logic             r_wrap [2];
    logic             n_wrap [2];
    logic r_act, n_act;

    // Walk counters.
    logic [COL_W-1:0]  r_fx, n_fx, r_fxe, n_fxe;
    logic [ROW_W-1:0]  r_fy, n_fy, r_fye, n_fye;
    logic [7:0]        r_fpal, n_fpal;
    logic [COL_W-1:0]  r_cx, n_cx;
    logic [ROW_W-1:0]  r_cy, n_cy;
    logic [5:0]        r_crem, n_crem;
    logic [5:0]        r_cn, n_cn;
    logic              r_cup, n_cup;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_rd_hit, n_rd_hit;

    // Output register.
    logic r_ovalid;
    logic [7:0] r_ochar, r_opal;
    logic [COL_W-1:0] r_ocol;
    logic [ROW_W-1:0] r_orow;
    logic r_oshown, r_oalt;

    // Current screen view.
    logic             s;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row, top, bot;
    logic [7:0]       cur_pal;
    logic [ARG_W-1:0] a0_or1, a1_or1, a1_or_rows, mode_arg;
    logic [5:0]       h6, arg_nn6;
    logic [5:0]       lf_row6;
    logic             lf_scroll;
    logic [ROW_W-1:0] lf_tmp, lf_row;
    logic [ROW_W-1:0] src_row;
    logic             rd_in_range;

    logic              pr_we;
    logic [ADDR_W-1:0] pr_addr;
    logic              plan_copy, plan_fill, plan_clr;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    assign s       = r_act;
    assign cur_col = r_col[s];
    assign cur_row = r_row[s];
    assign top     = r_top[s];
    assign bot     = r_bot[s];
    assign cur_pal = r_pal[s];

    assign a0_or1 = (r_argc != '0 && r_args[0] != '0) ? r_args[0] : 16'd1;
    assign a1_or1 = (r_argc >= ARGC_W'(2) && r_args[1] != '0) ? r_args[1] : 16'd1;
    assign a1_or_rows = (r_argc >= ARGC_W'(2) && r_args[1] != '0) ? r_args[1]
                                                                  : 16'(r_rows);
    assign mode_arg = (r_argc != '0) ? r_args[0] : '0;

    assign h6      = {1'b0, bot} - {1'b0, top} + 6'd1;
    assign arg_nn6 = (a0_or1 > 16'(h6)) ? h6 : a0_or1[5:0];

    // A line feed past the region bottom scrolls the region by one row.
    assign lf_row6   = {1'b0, cur_row} + 6'd1;
    assign lf_scroll = lf_row6 > {1'b0, bot};
    assign lf_tmp    = lf_scroll ? bot : lf_row6[4:0];
    assign lf_row    = ({1'b0, lf_tmp} >= r_rows) ? 5'(r_rows - 6'd1) : lf_tmp;

    assign src_row = r_cup ? 5'(r_cy + r_cn[4:0]) : 5'(r_cy - r_cn[4:0]);
    assign rd_in_range = ({1'b0, r_icol} < {1'b0, r_cols}) &&
                         ({1'b0, r_irow} < r_rows);

    always_comb begin
        logic             do_scroll;
        logic             sc_up;
        logic [5:0]       sc_nn;
        logic [5:0]       cnt6;
        logic             do_fill;
        logic [COL_W-1:0] f_xs, f_xe;
        logic [ROW_W-1:0] f_ys, f_ye;
        logic [7:0]       p;
        logic [ARG_W-1:0] v, t16;
        logic [ARGC_W-1:0] ac;
        logic [19:0]      acc;
        logic [7:0]       nx8;
        logic [16:0]      sum17;
        logic [ARG_W-1:0] ra, rb;

        n_cols = r_cols;   n_rows = r_rows;
        n_mode = r_mode;   n_args = r_args;   n_argc = r_argc;
        n_dseen = r_dseen; n_priv = r_priv;
        n_col = r_col;     n_row = r_row;     n_scol = r_scol;  n_srow = r_srow;
        n_pal = r_pal;     n_spal = r_spal;   n_top = r_top;    n_bot = r_bot;
        n_vis = r_vis;     n_wrap = r_wrap;   n_act = r_act;
        n_fx = r_fx; n_fy = r_fy; n_fxe = r_fxe; n_fye = r_fye; n_fpal = r_fpal;
        n_cx = r_cx; n_cy = r_cy; n_crem = r_crem; n_cn = r_cn; n_cup = r_cup;
        n_clr = r_clr;
        n_rd_hit = r_rd_hit;
        pr_we = 1'b0;
        pr_addr = cell_addr(s, cur_row, cur_col);
        plan_copy = 1'b0; plan_fill = 1'b0; plan_clr = 1'b0;
        do_scroll = 1'b0; sc_up = 1'b1; sc_nn = 6'd1;
        do_fill = 1'b0;
        f_xs = '0; f_xe = '0; f_ys = '0; f_ye = '0;
        p = cur_pal; v = '0; t16 = '0; ac = '0; acc = '0; nx8 = '0; sum17 = '0;
        ra = '0; rb = '0; cnt6 = '0;

        if (i_cmd.exec) begin
            n_rd_hit = (r_icmd == CMD_READ) && rd_in_range;
        end

        if (i_cmd.exec && r_icmd == CMD_FEED) begin
            unique case (r_mode)
                PM_NORMAL: begin
                    priority if (r_ibyte == CH_ESC) begin
                        n_mode = PM_ESC;
                    end else if (r_ibyte == CH_LF) begin
                        n_col[s] = '0;
                        n_row[s] = lf_row;
                        do_scroll = lf_scroll;
                    end else if (r_ibyte == CH_CR) begin
                        n_col[s] = '0;
                    end else if (r_ibyte == CH_BS) begin
                        if (cur_col != '0) n_col[s] = cur_col - 7'd1;
                    end else if (r_ibyte == CH_TAB) begin
                        nx8 = ({1'b0, cur_col} + 8'd4) & ~8'd3;
                        if (nx8 >= {1'b0, r_cols}) begin
                            n_col[s] = '0;
                            n_row[s] = lf_row;
                            do_scroll = lf_scroll;
                        end else begin
                            n_col[s] = nx8[6:0];
                        end
                    end else if (r_ibyte < CH_SP || r_ibyte == CH_DEL) begin
                        n_mode = PM_NORMAL;
                    end else begin
                        // Printable character: store it, then advance, or wrap or hold at the last column.
                        pr_we = (cur_col < r_cols) && ({1'b0, cur_row} < r_rows);
                        nx8 = {1'b0, cur_col} + 8'd1;
                        if (nx8 >= {1'b0, r_cols}) begin
                            if (r_wrap[s]) begin
                                n_col[s] = '0;
                                n_row[s] = lf_row;
                                do_scroll = lf_scroll;
                            end else begin
                                n_col[s] = r_cols - 7'd1;
                            end
                        end else begin
                            n_col[s] = nx8[6:0];
                        end
                    end
                end
                PM_ESC: begin
                    n_mode = PM_NORMAL;
                    priority if (r_ibyte == CH_LBR) begin
                        n_mode = PM_CSI;
                        for (int i = 0; i < ARG_SLOTS; i++) n_args[i] = '0;
                        n_argc = '0; n_dseen = 1'b0; n_priv = 1'b0;
                    end else if (r_ibyte == CH_SAVE) begin
                        n_scol[s] = cur_col; n_srow[s] = cur_row; n_spal[s] = cur_pal;
                    end else if (r_ibyte == CH_REST) begin
                        n_col[s] = r_scol[s]; n_row[s] = r_srow[s]; n_pal[s] = r_spal[s];
                    end else begin
                        n_mode = PM_NORMAL;
                    end
                end
                PM_CSI: begin
                    ac = (r_argc == '0) ? ARGC_W'(1) : r_argc;
                    priority if (r_ibyte == CH_QM && !r_dseen && r_argc == '0) begin
                        n_priv = 1'b1;
                    end else if (r_ibyte >= CH_D0 && r_ibyte <= CH_D9) begin
                        n_argc = ac;
                        v   = r_args[ARGI_W'(ac - ARGC_W'(1))];
                        acc = {1'b0, v, 3'b0} + {3'b0, v, 1'b0} + 20'(r_ibyte - CH_D0);
                        n_args[ARGI_W'(ac - ARGC_W'(1))] =
                            (acc > 20'(ARG_LIMIT)) ? ARG_LIMIT : acc[15:0];
                        n_dseen = 1'b1;
                    end else if (r_ibyte == CH_SEMI) begin
                        n_argc = ac;
                        if (ac < ARGC_W'(ARG_SLOTS)) begin
                            n_args[ARGI_W'(ac)] = '0;
                            n_argc = ac + ARGC_W'(1);
                        end
                        n_dseen = 1'b0;
                    end else begin
                        n_mode = PM_NORMAL;
                        if (r_ibyte >= FIN_LO && r_ibyte <= FIN_HI) begin
                            if (r_priv) begin
                                if (r_ibyte == FIN_SET || r_ibyte == FIN_RST) begin
                                    priority if (mode_arg == MODE_ALT) begin
                                        if (r_ibyte == FIN_SET && !r_act) begin
                                            // Enter the alternate screen from scratch.
                                            n_act = 1'b1;
                                            plan_clr = 1'b1;
                                            n_clr = ADDR_W'(SCREEN_CELLS);
                                            n_col[1] = '0;  n_row[1] = '0;
                                            n_scol[1] = '0; n_srow[1] = '0;
                                            n_pal[1] = '0;  n_spal[1] = '0;
                                            n_top[1] = '0;
                                            n_bot[1] = 5'(r_rows - 6'd1);
                                            n_vis[1] = 1'b1; n_wrap[1] = 1'b1;
                                        end else if (r_ibyte == FIN_RST && r_act) begin
                                            n_act = 1'b0;
                                        end
                                    end else if (mode_arg == MODE_CURSOR) begin
                                        n_vis[s] = (r_ibyte == FIN_SET);
                                    end else if (mode_arg == MODE_WRAP) begin
                                        n_wrap[s] = (r_ibyte == FIN_SET);
                                    end else begin
                                        // Other private modes are ignored.
                                    end
                                end
                            end else begin
                                unique case (r_ibyte)
                                    FIN_CUU: begin
                                        n_row[s] = (16'(cur_row) > a0_or1)
                                                 ? 5'(cur_row - a0_or1[4:0]) : '0;
                                    end
                                    FIN_CUD: begin
                                        sum17 = 17'(cur_row) + 17'(a0_or1);
                                        n_row[s] = (sum17 >= 17'(r_rows))
                                                 ? 5'(r_rows - 6'd1) : sum17[4:0];
                                    end
                                    FIN_CUF: begin
                                        sum17 = 17'(cur_col) + 17'(a0_or1);
                                        n_col[s] = (sum17 >= 17'(r_cols))
                                                 ? r_cols - 7'd1 : sum17[6:0];
                                    end
                                    FIN_CUB: begin
                                        n_col[s] = (16'(cur_col) > a0_or1)
                                                 ? 7'(cur_col - a0_or1[6:0]) : '0;
                                    end
                                    FIN_CUP, FIN_HVP: begin
                                        ra = (a0_or1 > 16'(r_rows)) ? 16'(r_rows) : a0_or1;
                                        rb = (a1_or1 > 16'(r_cols)) ? 16'(r_cols) : a1_or1;
                                        n_row[s] = 5'(ra - 16'd1);
                                        n_col[s] = 7'(rb - 16'd1);
                                    end
                                    FIN_ED: begin
                                        priority if (mode_arg == 16'd0) begin
                                            if ({1'b0, cur_row} < r_rows) begin
                                                f_xe = r_cols - 7'd1;
                                                f_ye = 5'(r_rows - 6'd1);
                                                if (cur_col < r_cols) begin
                                                    do_fill = 1'b1;
                                                    f_xs = cur_col; f_ys = cur_row;
                                                end else if (lf_row6 < r_rows) begin
                                                    do_fill = 1'b1;
                                                    f_xs = '0; f_ys = lf_row6[4:0];
                                                end
                                            end
                                        end else if (mode_arg == 16'd1) begin
                                            do_fill = 1'b1;
                                            f_xs = '0; f_ys = '0;
                                            if ({1'b0, cur_row} < r_rows) begin
                                                f_ye = cur_row;
                                                f_xe = (cur_col < r_cols) ? cur_col
                                                                          : r_cols - 7'd1;
                                            end else begin
                                                f_ye = cur_row - 5'd1;
                                                f_xe = r_cols - 7'd1;
                                            end
                                        end else if (mode_arg == 16'd2) begin
                                            do_fill = 1'b1;
                                            f_xs = '0; f_ys = '0;
                                            f_xe = r_cols - 7'd1;
                                            f_ye = 5'(r_rows - 6'd1);
                                        end else begin
                                            // Other erase modes are ignored.
                                        end
                                    end
                                    FIN_EL: begin
                                        f_ys = cur_row; f_ye = cur_row;
                                        f_xs = '0; f_xe = r_cols - 7'd1;
                                        if ({1'b0, cur_row} < r_rows) begin
                                            priority if (mode_arg == 16'd0) begin
                                                f_xs = cur_col;
                                                do_fill = (cur_col < r_cols);
                                            end else if (mode_arg == 16'd1) begin
                                                f_xe = (cur_col < r_cols) ? cur_col
                                                                          : r_cols - 7'd1;
                                                do_fill = 1'b1;
                                            end else if (mode_arg == 16'd2) begin
                                                do_fill = 1'b1;
                                            end else begin
                                                // Other erase modes are ignored.
                                            end
                                        end
                                    end
                                    FIN_SGR: begin
                                        if (r_argc == '0) begin
                                            p = '0;
                                        end else begin
                                            for (int i = 0; i < ARG_SLOTS; i++) begin
                                                if (ARGC_W'(i) < r_argc) begin
                                                    v = r_args[i];
                                                    priority if (v == 16'd0) begin
                                                        p = '0;
                                                    end else if (v >= 16'd30 && v <= 16'd37) begin
                                                        t16 = v - 16'd30;
                                                        p = (p & PAL_FG_MASK) | {5'b0, t16[2:0]};
                                                    end else if (v >= 16'd40 && v <= 16'd47) begin
                                                        t16 = v - 16'd40;
                                                        p = (p & PAL_BG_MASK)
                                                          | {1'b0, t16[2:0], 4'b0};
                                                    end else if (v == 16'd1) begin
                                                        p = p | PAL_BOLD;
                                                    end else begin
                                                        // Other attributes keep the palette.
                                                    end
                                                end
                                            end
                                        end
                                        n_pal[s] = p;
                                    end
                                    FIN_STB: begin
                                        rb = (a1_or_rows > 16'(r_rows)) ? 16'(r_rows)
                                                                        : a1_or_rows;
                                        if (a0_or1 < rb) begin
                                            n_top[s] = 5'(a0_or1 - 16'd1);
                                            n_bot[s] = 5'(rb - 16'd1);
                                            n_col[s] = '0;
                                            n_row[s] = 5'(a0_or1 - 16'd1);
                                        end
                                    end
                                    FIN_SCP: begin
                                        n_scol[s] = cur_col; n_srow[s] = cur_row;
                                        n_spal[s] = cur_pal;
                                    end
                                    FIN_RCP: begin
                                        n_col[s] = r_scol[s]; n_row[s] = r_srow[s];
                                        n_pal[s] = r_spal[s];
                                    end
                                    FIN_SU: begin
                                        do_scroll = 1'b1; sc_up = 1'b1; sc_nn = arg_nn6;
                                    end
                                    FIN_SD: begin
                                        do_scroll = 1'b1; sc_up = 1'b0; sc_nn = arg_nn6;
                                    end
                                    default: n_mode = PM_NORMAL;
                                endcase
                            end
                        end
                    end
                end
                default: n_mode = PM_NORMAL;
            endcase

            // A scroll copies the surviving rows, then blanks the vacated ones.
            if (do_scroll) begin
                cnt6 = h6 - sc_nn;
                n_cup = sc_up; n_cn = sc_nn; n_crem = cnt6; n_cx = '0;
                n_cy = sc_up ? top : bot;
                plan_copy = (cnt6 != '0);
                do_fill = 1'b1;
                f_xs = '0; f_xe = r_cols - 7'd1;
                f_ys = sc_up ? 5'({1'b0, bot} + 6'd1 - sc_nn) : top;
                f_ye = sc_up ? bot : 5'({1'b0, top} + sc_nn - 6'd1);
            end
            if (do_fill) begin
                plan_fill = 1'b1;
                n_fx = f_xs; n_fy = f_ys; n_fxe = f_xe; n_fye = f_ye;
                n_fpal = cur_pal;
            end
        end

        if (i_cmd.fill_step) begin
            if (r_fx == r_cols - 7'd1) begin
                n_fx = '0;
                n_fy = r_fy + 5'd1;
            end else begin
                n_fx = r_fx + 7'd1;
            end
        end

        if (i_cmd.copy_wr) begin
            if (r_cx == r_cols - 7'd1) begin
                n_cx = '0;
                n_cy = r_cup ? r_cy + 5'd1 : r_cy - 5'd1;
                n_crem = r_crem - 6'd1;
            end else begin
                n_cx = r_cx + 7'd1;
            end
        end

        if (i_cmd.clr_step) begin
            n_clr = r_clr + ADDR_W'(1);
        end

        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_COLS) begin
                n_cols = (i_cfg_data == '0) ? 7'd1
                       : (i_cfg_data > 7'(MAX_COLS)) ? 7'(MAX_COLS) : i_cfg_data;
            end else begin
                n_rows = (i_cfg_data[5:0] == '0) ? 6'd1
                       : (i_cfg_data[5:0] > 6'(MAX_ROWS)) ? 6'(MAX_ROWS)
                       : i_cfg_data[5:0];
            end
        end
    end

    // Cell store port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pr_addr;
        mem_wdata = {cur_pal, r_ibyte};
        mem_re    = 1'b0;
        mem_raddr = cell_addr(s, r_irow, r_icol);
        priority if (pr_we) begin
            mem_we = 1'b1;
        end else if (i_cmd.fill_step) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(s, r_fy, r_fx);
            mem_wdata = {r_fpal, 8'h00};
        end else if (i_cmd.copy_wr) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(s, r_cy, r_cx);
            mem_wdata = r_rdata;
        end else if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end
        if (i_cmd.copy_rd) begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr(s, src_row, r_cx);
        end else if (i_cmd.exec && r_icmd == CMD_READ && rd_in_range) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_icmd  <= i_in_cmd;
            r_ibyte <= i_in_byte;
            r_icol  <= i_in_col;
            r_irow  <= i_in_row;
        end
        r_fx <= n_fx; r_fy <= n_fy; r_fxe <= n_fxe; r_fye <= n_fye; r_fpal <= n_fpal;
        r_cx <= n_cx; r_cy <= n_cy; r_crem <= n_crem; r_cn <= n_cn; r_cup <= n_cup;
        r_args <= n_args;
        if (i_cmd.load_out) begin
            r_ochar  <= r_rd_hit ? r_rdata[7:0] : 8'h00;
            r_opal   <= r_rd_hit ? r_rdata[15:8] : 8'h00;
            r_ocol   <= r_col[s];
            r_orow   <= r_row[s];
            r_oshown <= r_vis[s];
            r_oalt   <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
            r_mode <= PM_NORMAL;
            r_argc <= '0;
            r_dseen <= 1'b0;
            r_priv <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_col[i] <= '0;  r_row[i] <= '0;
                r_scol[i] <= '0; r_srow[i] <= '0;
                r_pal[i] <= '0;  r_spal[i] <= '0;
                r_top[i] <= '0;
                r_bot[i] <= 5'(ROWS_RESET - 6'd1);
                r_vis[i] <= 1'b1; r_wrap[i] <= 1'b1;
            end
            r_act <= 1'b0;
            r_clr <= '0;
            r_rd_hit <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cols <= n_cols;  r_rows <= n_rows;
            r_mode <= n_mode;  r_argc <= n_argc;
            r_dseen <= n_dseen; r_priv <= n_priv;
            r_col <= n_col;   r_row <= n_row;   r_scol <= n_scol; r_srow <= n_srow;
            r_pal <= n_pal;   r_spal <= n_spal; r_top <= n_top;   r_bot <= n_bot;
            r_vis <= n_vis;   r_wrap <= n_wrap; r_act <= n_act;
            r_clr <= n_clr;
            r_rd_hit <= n_rd_hit;
            if (i_cmd.load_out) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_stat.plan_copy = plan_copy;
    assign o_stat.plan_fill = plan_fill;
    assign o_stat.plan_clr  = plan_clr;
    assign o_stat.fill_last = (r_fx == r_fxe) && (r_fy == r_fye);
    assign o_stat.copy_last = (r_cx == r_cols - 7'd1) && (r_crem == 6'd1);
    assign o_stat.clr_last  = (r_clr == ADDR_W'(ALL_CELLS - 1));
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_out_char  = r_ochar;
    assign o_out_pal   = r_opal;
    assign o_out_col   = r_ocol;
    assign o_out_row   = r_orow;
    assign o_out_shown = r_oshown;
    assign o_out_alt   = r_oalt;

endmodule

[src/ansi_text_terminal.sv]
// Top level of the ANSI text terminal: controller, datapath and channel wiring.
//
//  channel   dir  transaction contents
//  i_req     in   cmd, data_byte, read_col, read_row
//  o_rsp     out  cell_char, cell_palette, cursor_col/row, cursor_shown, alt_active
//  i_cfg_*   in   write of screen_cols (index 0) or screen_rows (index 1)
//
// An ordinary byte or a cell read is accepted, executed, then loaded as a result.
// Erase and scroll walks blank one cell per step and copy each cell with a read
// step then a write step, on the single write and read port of the cell store.
// After reset the whole store is cleared before the first transaction;
// entering the alternate screen clears its half of the store.
// A result waits in the output register while the next transaction is taken.
module ansi_text_terminal
    import att_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    att_in_if.sink     i_req,
    att_out_if.source  o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [6:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    att_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    att_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_cmd    (i_req.cmd),
        .i_in_byte   (i_req.data_byte),
        .i_in_col    (i_req.read_col),
        .i_in_row    (i_req.read_row),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out_char  (o_rsp.cell_char),
        .o_out_pal   (o_rsp.cell_palette),
        .o_out_col   (o_rsp.cursor_col),
        .o_out_row   (o_rsp.cursor_row),
        .o_out_shown (o_rsp.cursor_shown),
        .o_out_alt   (o_rsp.alt_active)
    );

endmodule

[dv/att_scoreboard.sv]
// Scoreboard for the ANSI text terminal: screen predictor and result checker.
`timescale 1ns / 100ps

class att_scoreboard;
    localparam int NCOL = att_pkg::MAX_COLS;
    localparam int NROW = att_pkg::MAX_ROWS;
    localparam int NCELL = NCOL * NROW;
    localparam int NARG = att_pkg::ARG_SLOTS;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] pal;
        logic [6:0] col;
        logic [4:0] row;
        logic       shown;
        logic       alt;
    } t_status;

    int unsigned cols, rows;
    byte unsigned chars[2*NCELL];
    byte unsigned pals[2*NCELL];
    int unsigned mode;
    int unsigned args[NARG];
    int unsigned argc;
    bit          seen_digit, priv;
    int unsigned cx[2], cy[2], sx[2], sy[2], pen[2], spen[2], rtop[2], rbot[2];
    bit          shown[2], wrap[2];
    int unsigned scr;
    t_status     pending[$];
    int          errors;

    function new();
        cols = att_pkg::COLS_RESET;
        rows = att_pkg::ROWS_RESET;
        foreach (chars[i]) begin
            chars[i] = 0;
            pals[i] = 0;
        end
        mode = 0;
        wipe_args();
        scr = 0;
        init_screen(0);
        init_screen(1);
        errors = 0;
    endfunction

    function void wipe_args();
        foreach (args[i]) args[i] = 0;
        argc = 0;
        seen_digit = 0;
        priv = 0;
    endfunction

    function void init_screen(int unsigned s);
        cx[s] = 0; cy[s] = 0; sx[s] = 0; sy[s] = 0;
        pen[s] = 0; spen[s] = 0; rtop[s] = 0; rbot[s] = rows - 1;
        shown[s] = 1; wrap[s] = 1;
    endfunction

    function void set_size(bit idx, int unsigned v);
        if (v < 1) v = 1;
        if (idx == att_pkg::CFG_COLS) cols = (v > NCOL) ? NCOL : v;
        else rows = (v > NROW) ? NROW : v;
    endfunction

    function void raw_set(int unsigned x, int unsigned y, byte unsigned c,
                          byte unsigned p);
        int unsigned i;
        if (x >= NCOL || y >= NROW) return;
        i = scr * NCELL + y * NCOL + x;
        chars[i] = c;
        pals[i] = p;
    endfunction

    function void put(int unsigned x, int unsigned y, byte unsigned c);
        if (x >= cols || y >= rows) return;
        raw_set(x, y, c, 8'(pen[scr]));
    endfunction

    function void copy_row(int unsigned yd, int unsigned ys);
        int unsigned b;
        if (yd >= NROW || ys >= NROW) return;
        b = scr * NCELL;
        for (int unsigned x = 0; x < cols; x++) begin
            chars[b + yd*NCOL + x] = chars[b + ys*NCOL + x];
            pals[b + yd*NCOL + x] = pals[b + ys*NCOL + x];
        end
    endfunction

    function void blank_rows(int unsigned t, int unsigned b);
        for (int unsigned y = t; y <= b && y < NROW; y++)
            for (int unsigned x = 0; x < cols; x++) raw_set(x, y, 0, 8'(pen[scr]));
    endfunction

    function void scroll(int unsigned n, bit up);
        int unsigned t, b;
        t = rtop[scr];
        b = rbot[scr];
        if (n == 0 || b < t) return;
        if (n > b - t + 1) n = b - t + 1;
        if (up) begin
            for (int unsigned y = t; y + n <= b; y++) copy_row(y, y + n);
            blank_rows(b + 1 - n, b);
        end else begin
            for (int y = b; y >= int'(t + n); y--) copy_row(y, y - n);
            blank_rows(t, t + n - 1);
        end
    endfunction

    function void line_feed();
        cx[scr] = 0;
        cy[scr]++;
        if (cy[scr] > rbot[scr]) begin
            scroll(1, 1);
            cy[scr] = rbot[scr];
        end
        if (cy[scr] >= rows) cy[scr] = rows - 1;
    endfunction

    function int unsigned arg(int unsigned i, int unsigned dflt);
        if (i >= argc || i >= NARG || args[i] == 0) return dflt;
        return args[i];
    endfunction

    function void run_private(byte unsigned f);
        int unsigned m;
        m = argc ? args[0] : 0;
        if (f != att_pkg::FIN_SET && f != att_pkg::FIN_RST) return;
        if (m == att_pkg::MODE_ALT) begin
            if (f == att_pkg::FIN_SET && scr == 0) begin
                scr = 1;
                for (int i = NCELL; i < 2*NCELL; i++) begin
                    chars[i] = 0;
                    pals[i] = 0;
                end
                init_screen(1);
            end else if (f == att_pkg::FIN_RST && scr == 1) begin
                scr = 0;
            end
        end else if (m == att_pkg::MODE_CURSOR) begin
            shown[scr] = (f == att_pkg::FIN_SET);
        end else if (m == att_pkg::MODE_WRAP) begin
            wrap[scr] = (f == att_pkg::FIN_SET);
        end
    endfunction

    function void run_csi(byte unsigned f);
        int unsigned s, n, a, b, xs, xe, v, p;
        s = scr;
        if (priv) begin
            run_private(f);
            return;
        end
        case (f)
            att_pkg::FIN_CUU: begin
                n = arg(0, 1);
                cy[s] = (cy[s] > n) ? cy[s] - n : 0;
            end
            att_pkg::FIN_CUD: begin
                cy[s] += arg(0, 1);
                if (cy[s] >= rows) cy[s] = rows - 1;
            end
            att_pkg::FIN_CUF: begin
                cx[s] += arg(0, 1);
                if (cx[s] >= cols) cx[s] = cols - 1;
            end
            att_pkg::FIN_CUB: begin
                n = arg(0, 1);
                cx[s] = (cx[s] > n) ? cx[s] - n : 0;
            end
            att_pkg::FIN_CUP, att_pkg::FIN_HVP: begin
                a = arg(0, 1);
                b = arg(1, 1);
                if (a > rows) a = rows;
                if (b > cols) b = cols;
                cy[s] = a - 1;
                cx[s] = b - 1;
            end
            att_pkg::FIN_ED: begin
                n = argc ? args[0] : 0;
                if (n == 0) begin
                    for (int unsigned x = cx[s]; x < cols; x++) put(x, cy[s], 0);
                    if (cy[s] + 1 < rows) blank_rows(cy[s] + 1, rows - 1);
                end else if (n == 1) begin
                    if (cy[s] > 0) blank_rows(0, cy[s] - 1);
                    for (int unsigned x = 0; x <= cx[s] && x < cols; x++)
                        put(x, cy[s], 0);
                end else if (n == 2) begin
                    blank_rows(0, rows - 1);
                end
            end
            att_pkg::FIN_EL: begin
                n = argc ? args[0] : 0;
                xs = 0;
                xe = cols - 1;
                if (n == 0) xs = cx[s];
                else if (n == 1) xe = cx[s];
                if (n <= 2)
                    for (int unsigned x = xs; x <= xe && x < cols; x++) put(x, cy[s], 0);
            end
            att_pkg::FIN_SGR: begin
                if (argc == 0) pen[s] = 0;
                for (int unsigned i = 0; i < argc && i < NARG; i++) begin
                    v = args[i];
                    p = pen[s];
                    if (v == 0) p = 0;
                    else if (v >= 30 && v <= 37) p = (p & att_pkg::PAL_FG_MASK) | (v - 30);
                    else if (v >= 40 && v <= 47)
                        p = (p & att_pkg::PAL_BG_MASK) | ((v - 40) << 4);
                    else if (v == 1) p |= att_pkg::PAL_BOLD;
                    pen[s] = p & 8'hFF;
                end
            end
            att_pkg::FIN_STB: begin
                a = arg(0, 1);
                b = arg(1, rows);
                if (b > rows) b = rows;
                if (a < b) begin
                    rtop[s] = a - 1;
                    rbot[s] = b - 1;
                    cx[s] = 0;
                    cy[s] = a - 1;
                end
            end
            att_pkg::FIN_SCP: begin
                sx[s] = cx[s]; sy[s] = cy[s]; spen[s] = pen[s];
            end
            att_pkg::FIN_RCP: begin
                cx[s] = sx[s]; cy[s] = sy[s]; pen[s] = spen[s];
            end
            att_pkg::FIN_SU: scroll(arg(0, 1), 1);
            att_pkg::FIN_SD: scroll(arg(0, 1), 0);
            default: ;
        endcase
    endfunction

    function void feed(byte unsigned c);
        int unsigned s, nx, v;
        s = scr;
        if (mode == att_pkg::PM_NORMAL) begin
            if (c == att_pkg::CH_ESC) mode = att_pkg::PM_ESC;
            else if (c == att_pkg::CH_LF) line_feed();
            else if (c == att_pkg::CH_CR) cx[s] = 0;
            else if (c == att_pkg::CH_BS) begin
                if (cx[s] > 0) cx[s]--;
            end else if (c == att_pkg::CH_TAB) begin
                nx = (cx[s] + 4) & ~3;
                if (nx >= cols) line_feed();
                else cx[s] = nx;
            end else if (c >= att_pkg::CH_SP && c != att_pkg::CH_DEL) begin
                put(cx[s], cy[s], c);
                cx[s]++;
                if (cx[s] >= cols) begin
                    if (wrap[s]) line_feed();
                    else cx[s] = cols - 1;
                end
            end
            return;
        end
        if (mode == att_pkg::PM_ESC) begin
            mode = att_pkg::PM_NORMAL;
            if (c == att_pkg::CH_LBR) begin
                mode = att_pkg::PM_CSI;
                wipe_args();
            end else if (c == att_pkg::CH_SAVE) begin
                sx[s] = cx[s]; sy[s] = cy[s]; spen[s] = pen[s];
            end else if (c == att_pkg::CH_REST) begin
                cx[s] = sx[s]; cy[s] = sy[s]; pen[s] = spen[s];
            end
            return;
        end
        if (c == att_pkg::CH_QM && !seen_digit && argc == 0) begin
            priv = 1;
            return;
        end
        if (c >= att_pkg::CH_D0 && c <= att_pkg::CH_D9) begin
            if (argc == 0) argc = 1;
            if (argc - 1 < NARG) begin
                v = args[argc-1] * 10 + (c - att_pkg::CH_D0);
                args[argc-1] = (v > 65535) ? 65535 : v;
            end
            seen_digit = 1;
            return;
        end
        if (c == att_pkg::CH_SEMI) begin
            if (argc == 0) argc = 1;
            if (argc < NARG) begin
                args[argc] = 0;
                argc++;
            end
            seen_digit = 0;
            return;
        end
        if (c >= att_pkg::FIN_LO && c <= att_pkg::FIN_HI) run_csi(c);
        mode = att_pkg::PM_NORMAL;
    endfunction

    // Apply one accepted request and queue the status it should produce.
    function void note_request(bit cmd, byte unsigned b, int unsigned rc, int unsigned rr);
        t_status e;
        int unsigned i;
        e.ch = 0;
        e.pal = 0;
        if (cmd == att_pkg::CMD_FEED) feed(b);
        else if (rc < cols && rr < rows) begin
            i = scr * NCELL + rr * NCOL + rc;
            e.ch = chars[i];
            e.pal = pals[i];
        end
        e.col = 7'(cx[scr]);
        e.row = 5'(cy[scr]);
        e.shown = shown[scr];
        e.alt = 1'(scr);
        pending.push_back(e);
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
        $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endfunction

    function void check_status(t_status got);
        t_status e;
        if (pending.size() == 0) begin
            $display("tb: unexpected result at %0t", $realtime);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.ch !== e.ch) report("cell_char", got.ch, e.ch);
        if (got.pal !== e.pal) report("cell_palette", got.pal, e.pal);
        if (got.col !== e.col) report("cursor_col", got.col, e.col);
        if (got.row !== e.row) report("cursor_row", got.row, e.row);
        if (got.shown !== e.shown) report("cursor_shown", got.shown, e.shown);
        if (got.alt !== e.alt) report("alt_active", got.alt, e.alt);
    endfunction
endclass

[dv/tb.sv]
// Testbench top: drives the terminal with byte streams and cell reads.
`timescale 1ns / 100ps

module tb;
    import att_pkg::*;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       cfg_we = 0;
    logic       cfg_idx = 0;
    logic [6:0] cfg_data = 0;
    int         idle_cycles = 0;
    bit         timed_out = 0;
    int         wrap_stalls = 1;

    att_in_if  req();
    att_out_if rsp();
    att_scoreboard screen_sb;

    ansi_text_terminal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req.sink), .o_rsp(rsp.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    initial begin
        req.valid = 0; req.cmd = 0; req.data_byte = 0; req.read_col = 0; req.read_row = 0;
        rsp.ready = 0;
        screen_sb = new();
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, long stretches with none at all.
    always @(posedge i_clk) begin
        if (rsp.valid && rsp.ready) begin
            screen_sb.check_status({rsp.cell_char, rsp.cell_palette, rsp.cursor_col,
                                    rsp.cursor_row, rsp.cursor_shown, rsp.alt_active});
        end
        if (!i_rst_n) rsp.ready <= 0;
        else if (wrap_stalls == 0) rsp.ready <= 1;
        else rsp.ready <= ($urandom_range(0, 99) < 65);
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 60000 && !timed_out) begin
            timed_out = 1;
            $display("tb: done, errors");
            $finish;
        end
    end

    // Valid stays high between back-to-back transactions and drops for a gap or in drain().
    task automatic send(bit cmd, byte unsigned b, int unsigned rc, int unsigned rr);
        int g;
        g = gap_len();
        if (g > 0) begin
            req.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        req.valid <= 1;
        req.cmd <= cmd;
        req.data_byte <= b;
        req.read_col <= 7'(rc);
        req.read_row <= 5'(rr);
        do @(posedge i_clk); while (!req.ready);
        screen_sb.note_request(cmd, b, rc, rr);
    endtask

    task automatic put_byte(byte unsigned b);
        send(CMD_FEED, b, $urandom_range(0, 127), $urandom_range(0, 31));
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic read_cell(int unsigned rc, int unsigned rr);
        send(CMD_READ, 8'($urandom_range(0, 255)), rc, rr);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (screen_sb.pending.size() != 0) @(posedge i_clk);
        repeat (6000) @(posedge i_clk);
    endtask

    task automatic write_size(bit idx, int unsigned v);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= 7'(v);
        @(posedge i_clk);
        cfg_we <= 0;
        screen_sb.set_size(idx, v & (idx ? 8'h3F : 8'h7F));
        @(posedge i_clk);
    endtask

    task automatic put_number(int unsigned n);
        put_text($sformatf("%0d", n));
    endtask

    // One random terminal sequence, mostly well formed.
    task automatic random_sequence();
        int unsigned k, na;
        byte unsigned finals[16];
        finals = '{FIN_CUU, FIN_CUD, FIN_CUF, FIN_CUB, FIN_CUP, FIN_HVP, FIN_ED, FIN_EL,
                   FIN_SGR, FIN_STB, FIN_SCP, FIN_RCP, FIN_SU, FIN_SD, FIN_SGR, 8'h5A};
        k = $urandom_range(0, 99);
        if (k < 35) begin
            put_byte(8'($urandom_range(32, 126)));
        end else if (k < 45) begin
            put_byte(8'($urandom_range(0, 255)));
        end else if (k < 52) begin
            case ($urandom_range(0, 3))
                0: put_byte(CH_LF);
                1: put_byte(CH_CR);
                2: put_byte(CH_BS);
                default: put_byte(CH_TAB);
            endcase
        end else if (k < 70) begin
            read_cell($urandom_range(0, 85), $urandom_range(0, 31));
        end else if (k < 93) begin
            put_byte(CH_ESC);
            put_byte(CH_LBR);
            if ($urandom_range(0, 9) == 0) begin
                put_byte(CH_QM);
                case ($urandom_range(0, 3))
                    0: put_number(MODE_CURSOR);
                    1: put_number(MODE_WRAP);
                    2: put_number(MODE_ALT);
                    default: put_number($urandom_range(0, 99));
                endcase
                put_byte($urandom_range(0, 1) ? FIN_SET : FIN_RST);
            end else begin
                na = $urandom_range(0, 3);
                for (int i = 0; i < na; i++) begin
                    if (i) put_byte(CH_SEMI);
                    if ($urandom_range(0, 4)) put_number($urandom_range(0, 48));
                end
                if ($urandom_range(0, 19) == 0) put_byte(8'($urandom_range(0, 255)));
                else put_byte(finals[$urandom_range(0, 15)]);
            end
        end else begin
            put_byte(CH_ESC);
            put_byte($urandom_range(0, 1) ? CH_SAVE : ($urandom_range(0, 1) ? CH_REST :
                                                       8'($urandom_range(0, 255))));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: printing, controls, parameters, modes and the read range edges.
        put_text("Az~\t\010\015\n");
        put_byte(8'hFF);
        put_byte(CH_DEL);
        put_byte(8'h01);
        put_text("\033[99999;2H\033[1;31;47mQ\033[s\033[5;3r\033[2S\033[T");
        put_text("\033[1K\033[2J\033[u\033[;5f\0337\0338\033[3A\033[B\033[C\033[D");
        put_text("\033[?7l\033[?25l\033[?1049hX\033[?1049h\033[?1049l\033[?1049l");
        put_text("\033[1;2;3;4;5;6;7;8;9;10;11m\033[0K\033[9J\033[zq\033[1\001");
        read_cell(0, 0);
        read_cell(79, 31);
        read_cell(127, 31);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_size(CFG_COLS, 0); write_size(CFG_ROWS, 1); end
                1: begin write_size(CFG_COLS, 80); write_size(CFG_ROWS, 32); end
                2: begin write_size(CFG_COLS, 127); write_size(CFG_ROWS, 63); end
                3: begin write_size(CFG_COLS, 8); write_size(CFG_ROWS, 4); end
                default: begin
                    write_size(CFG_COLS, $urandom_range(1, 80));
                    write_size(CFG_ROWS, $urandom_range(1, 32));
                end
            endcase
            wrap_stalls = (phase != 2);
            for (int n = 0; n < 160; n++) random_sequence();
            drain();
        end

        drain();
        if (screen_sb.errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end
endmodule

[sim.f]
src/att_pkg.sv
src/att_in_if.sv
src/att_out_if.sv
src/att_ctrl.sv
src/att_dp.sv
src/ansi_text_terminal.sv
dv/att_scoreboard.sv
dv/tb.sv
